FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the noise block, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FPN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define FPN_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FPN_ASSERT(lbl, clk, rst, prop, msg)
`define FPN_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: src/fpn_pkg.sv
// ----------------------------------------------------------------------------
// fpn_pkg
// shared widths, permutation rom, gradient function and types of the noise block
// ----------------------------------------------------------------------------
package fpn_pkg;

  localparam int COORD_W    = 32;
  localparam int Q_BITS     = 16;
  localparam int LAYER_W    = 19;
  localparam int GRAD_IN_W  = 18;
  localparam int FADE_W     = 17;
  localparam int AMP_W      = 17;
  localparam int PERS_W     = 16;
  localparam int PROD_W     = LAYER_W + AMP_W + 1;
  localparam int OCT_CFG_W  = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 16;
  localparam int QUOT_W     = 17;
  localparam int LAYER_LAT  = 10;
  localparam int DIV_LAT    = 2 + QUOT_W;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 4'd1;

  localparam logic [OCT_CFG_W-1:0] OCT_RESET  = 4'd0;
  localparam logic [PERS_W-1:0]    PERS_RESET = 16'd32768;
  localparam logic [AMP_W-1:0]     AMP_ONE    = 17'd65536;

  typedef struct packed {
    logic [OCT_CFG_W-1:0] count;
    logic [PERS_W-1:0]    persistence;
  } oct_cfg_t;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  // 12-direction gradient dotted with the corner offset
  function automatic logic signed [LAYER_W-1:0] grad(input logic [3:0] h,
                                                     input logic signed [GRAD_IN_W-1:0] x,
                                                     input logic signed [GRAD_IN_W-1:0] y,
                                                     input logic signed [GRAD_IN_W-1:0] z);
    logic signed [GRAD_IN_W-1:0] u;
    logic signed [GRAD_IN_W-1:0] v;
    logic signed [LAYER_W-1:0]   ue;
    logic signed [LAYER_W-1:0]   ve;
    u  = (h < 4'd8) ? x : y;
    v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    ue = {u[GRAD_IN_W-1], u};
    ve = {v[GRAD_IN_W-1], v};
    return (h[0] ? -ue : ue) + (h[1] ? -ve : ve);
  endfunction

endpackage

FILE: src/fractal_perlin_noise_3d.sv
// ----------------------------------------------------------------------------
// fractal_perlin_noise_3d
// fractal 3d improved noise, one sample per clock while not stalled, normalized to unsigned q0.16
// ----------------------------------------------------------------------------
// The block takes one signed Q16.16 point (for the default FRAC_BITS) per
// clock while coord_stall is low and returns one unsigned Q0.16 noise sample
// per point, in order. Every octave has its own noise pipeline, so all
// octaves run side by side and a new point can enter in every unstalled
// cycle; the sustained rate is one transaction per cycle while results drain.
// A result passes the input register, which loads at the accepting edge,
// then 10 stages of noise (hash, fade, gradients, three blend levels),
// MAX_OCTAVES + 1 stages of weighted sum, 19 stages of divider (two setup
// stages, then one quotient bit each) and the output register.
// The output has a two-entry buffer: the block keeps taking points while one
// finished sample waits, and raises coord_stall only when both entries are
// full. Configuration (octave_count, persistence) goes through the cfg port,
// which is always ready; write it only while no point is in flight.
module fractal_perlin_noise_3d
  import fpn_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // point channel
  input  logic                  coord_valid,
  output logic                  coord_stall,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [COORD_W-1:0]    coord_z,
  // result channel
  output logic                  noise_valid,
  input  logic                  noise_stall,
  output logic [OUT_W-1:0]      noise_value,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  // sum and weight widths follow the octave count
  localparam int TOT_W    = PROD_W + $clog2(MAX_OCTAVES) + 1;
  localparam int MAXV_W   = AMP_W + $clog2(MAX_OCTAVES + 1);
  localparam int PIPE_LAT = LAYER_LAT + MAX_OCTAVES + 1 + DIV_LAT;

  // configuration registers
  logic [OCT_CFG_W-1:0] octave_count;
  logic [PERS_W-1:0]    persistence;
  oct_cfg_t             oct_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCT_RESET;
      persistence  <= PERS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_CFG_W-1:0];
        REG_PERSISTENCE:  persistence  <= cfg_data[PERS_W-1:0];
        default:          ;  // writes to unknown registers are dropped
      endcase
    end
  end

  // zero means one layer, anything above the unrolled count is clipped
  always_comb begin
    oct_cfg.persistence = persistence;
    if (octave_count == '0) begin
      oct_cfg.count = OCT_CFG_W'(1);
    end else if (octave_count > OCT_CFG_W'(MAX_OCTAVES)) begin
      oct_cfg.count = OCT_CFG_W'(MAX_OCTAVES);
    end else begin
      oct_cfg.count = octave_count;
    end
  end

  // pipeline advance: the whole datapath moves unless the output buffer is full
  logic [1:0] cnt;
  logic       en;
  logic       push;
  logic       pop;

  assign en          = (cnt != 2'd2);
  assign coord_stall = !en;

  // input register and valid bits that travel with each transaction
  logic [2:0][COORD_W-1:0] coord;
  logic [PIPE_LAT:0]       vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-1:0], coord_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= {coord_z, coord_y, coord_x};
    end
  end

  // one noise pipeline per octave, octave i samples the point shifted by i
  logic [MAX_OCTAVES-1:0][LAYER_W-1:0] layers;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_layer
    fpn_layer #(
      .FRAC_BITS (FRAC_BITS),
      .SHIFT     (i)
    ) u_layer (
      .clk   (clk),
      .en    (en),
      .coord (coord),
      .layer (layers[i])
    );
  end

  // weighted sum and total weight
  logic signed [TOT_W-1:0] total;
  logic [MAXV_W-1:0]       maxv;

  fpn_accum #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .TOT_W       (TOT_W),
    .MAXV_W      (MAXV_W)
  ) u_accum (
    .clk    (clk),
    .en     (en),
    .layers (layers),
    .cfg    (oct_cfg),
    .total  (total),
    .maxv   (maxv)
  );

  // normalization, truncated toward zero
  div_res_t res;

  fpn_div #(
    .TOT_W  (TOT_W),
    .MAXV_W (MAXV_W)
  ) u_div (
    .clk   (clk),
    .en    (en),
    .total (total),
    .maxv  (maxv),
    .res   (res)
  );

  // map [-1,1] to [0,1] with saturation on both ends
  logic signed [QUOT_W+1:0] shifted;
  logic [OUT_W-1:0]         result;

  always_comb begin
    shifted = res.neg ? ((QUOT_W+2)'(65536) - (QUOT_W+2)'(res.quot))
                      : ((QUOT_W+2)'(65536) + (QUOT_W+2)'(res.quot));
    if (res.ovf) begin
      result = res.neg ? '0 : '1;
    end else if (shifted[QUOT_W+1]) begin
      result = '0;
    end else if (shifted[QUOT_W]) begin
      result = '1;
    end else begin
      result = shifted[OUT_W:1];
    end
  end

  // two-entry output buffer: head drives the port, skid catches one more
  logic [OUT_W-1:0] head;
  logic [OUT_W-1:0] skid;

  assign push        = en && vld[PIPE_LAT];
  assign pop         = noise_valid && !noise_stall;
  assign noise_valid = (cnt != 2'd0);
  assign noise_value = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      head <= skid;
    end else if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      head <= result;
    end
    if (push && cnt == 2'd1 && !pop) begin
      skid <= result;
    end
  end

  // buffer never holds more than two results
  `FPN_ASSERT_NEVER(a_cnt_range, clk, rst, cnt == 2'd3, "output buffer overflow")
  // a result pushed into an empty buffer is offered in the next cycle
  `FPN_ASSERT(a_push_shows, clk, rst, (push && cnt == 2'd0) |=> noise_valid, "result lost")
  // a finished result waiting on a frozen pipeline stays in place
  `FPN_ASSERT(a_hold_last, clk, rst, (vld[PIPE_LAT] && !en) |=> vld[PIPE_LAT], "held result dropped")
  // full buffer with no transaction taken keeps the input side stalled
  `FPN_ASSERT(a_full_stall, clk, rst, (cnt == 2'd2 && !pop) |=> coord_stall, "input taken while full")

endmodule

FILE: src/fpn_layer.sv
// ----------------------------------------------------------------------------
// fpn_layer
// one octave of 3d improved noise: hash, fade, gradients and trilinear blend
// ----------------------------------------------------------------------------
module fpn_layer
  import fpn_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int SHIFT     = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [2:0][COORD_W-1:0]           coord,
  output logic signed [LAYER_W-1:0]         layer
);

  localparam int BPROD_W = FADE_W + LAYER_W + 2;

  function automatic logic signed [BPROD_W-1:0] blend_mul(input logic [FADE_W-1:0] w,
                                                          input logic signed [LAYER_W-1:0] a,
                                                          input logic signed [LAYER_W-1:0] b);
    logic signed [LAYER_W:0]  d;
    logic signed [FADE_W:0]   ws;
    d  = {b[LAYER_W-1], b} - {a[LAYER_W-1], a};
    ws = {1'b0, w};
    return BPROD_W'(ws) * BPROD_W'(d);
  endfunction

  function automatic logic signed [LAYER_W-1:0] blend_add(input logic signed [LAYER_W-1:0] a,
                                                          input logic signed [BPROD_W-1:0] p);
    logic signed [BPROD_W-Q_BITS-1:0] sh;
    logic signed [BPROD_W-Q_BITS-1:0] sum;
    sh  = p[BPROD_W-1:Q_BITS];
    sum = {{(BPROD_W-Q_BITS-LAYER_W){a[LAYER_W-1]}}, a} + sh;
    return sum[LAYER_W-1:0];
  endfunction

  // stage 1: lattice cell, fraction, square, first hash level
  logic [COORD_W-1:0] sc   [3];
  logic [7:0]         lat  [3];
  logic [15:0]        frac [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign sc[k]   = coord[k] << SHIFT;
    assign lat[k]  = sc[k][FRAC_BITS+7:FRAC_BITS];
    if (FRAC_BITS >= Q_BITS) begin : g_dn
      assign frac[k] = sc[k][FRAC_BITS-1 -: Q_BITS];
    end else begin : g_up
      assign frac[k] = {sc[k][FRAC_BITS-1:0], {(Q_BITS-FRAC_BITS){1'b0}}};
    end
  end

  logic [15:0] frac1 [3];
  logic [31:0] sq1   [3];
  logic [7:0]  ha1;
  logic [7:0]  hb1;
  logic [7:0]  cz1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        frac1[k] <= frac[k];
        sq1[k]   <= 32'(frac[k]) * 32'(frac[k]);
      end
      ha1 <= perm(lat[0]) + lat[1];
      hb1 <= perm(lat[0] + 8'd1) + lat[1];
      cz1 <= lat[2];
    end
  end

  // stage 2: second hash level, cube and fade polynomial
  logic [15:0] frac2 [3];
  logic [15:0] cube2 [3];
  logic [19:0] poly2 [3];
  logic [7:0]  aa2, ab2, ba2, bb2;
  logic [35:0] poly  [3];
  logic [31:0] cube  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      poly[k] = 36'(sq1[k]) * 36'd6 + (36'd10 << 32) - ((36'(frac1[k]) * 36'd15) << 16);
      cube[k] = 32'(sq1[k][31:16]) * 32'(frac1[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        frac2[k] <= frac1[k];
        cube2[k] <= cube[k][31:16];
        poly2[k] <= poly[k][35:16];
      end
      aa2 <= perm(ha1) + cz1;
      ab2 <= perm(ha1 + 8'd1) + cz1;
      ba2 <= perm(hb1) + cz1;
      bb2 <= perm(hb1 + 8'd1) + cz1;
    end
  end

  // stage 3: corner hashes and fade weights, clamped to one
  logic [15:0]       frac3 [3];
  logic [FADE_W-1:0] fade3 [3];
  logic [3:0]        hash3 [8];
  logic [35:0]       fprod [3];
  logic [7:0]        hv    [8];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fprod[k] = 36'(cube2[k]) * 36'(poly2[k]);
    end
    hv[0] = perm(aa2);
    hv[1] = perm(ba2);
    hv[2] = perm(ab2);
    hv[3] = perm(bb2);
    hv[4] = perm(aa2 + 8'd1);
    hv[5] = perm(ba2 + 8'd1);
    hv[6] = perm(ab2 + 8'd1);
    hv[7] = perm(bb2 + 8'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        frac3[k] <= frac2[k];
        fade3[k] <= (fprod[k][35:16] > 20'd65536) ? AMP_ONE : fprod[k][32:16];
      end
      for (int j = 0; j < 8; j++) begin
        hash3[j] <= hv[j][3:0];
      end
    end
  end

  // stage 4: gradients at the eight corners
  logic signed [GRAD_IN_W-1:0] p0 [3];
  logic signed [GRAD_IN_W-1:0] p1 [3];
  logic signed [LAYER_W-1:0]   grad4 [8];
  logic [FADE_W-1:0]           fade4 [3];

  for (genvar k = 0; k < 3; k++) begin : g_off
    assign p0[k] = {2'b00, frac3[k]};
    assign p1[k] = {2'b11, frac3[k]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fade4    <= fade3;
      grad4[0] <= grad(hash3[0], p0[0], p0[1], p0[2]);
      grad4[1] <= grad(hash3[1], p1[0], p0[1], p0[2]);
      grad4[2] <= grad(hash3[2], p0[0], p1[1], p0[2]);
      grad4[3] <= grad(hash3[3], p1[0], p1[1], p0[2]);
      grad4[4] <= grad(hash3[4], p0[0], p0[1], p1[2]);
      grad4[5] <= grad(hash3[5], p1[0], p0[1], p1[2]);
      grad4[6] <= grad(hash3[6], p0[0], p1[1], p1[2]);
      grad4[7] <= grad(hash3[7], p1[0], p1[1], p1[2]);
    end
  end

  // stages 5 to 10: blend along x, then y, then z
  logic signed [BPROD_W-1:0] px5 [4];
  logic signed [LAYER_W-1:0] ax5 [4];
  logic [FADE_W-1:0]         fv5, fw5;
  logic signed [LAYER_W-1:0] lx6 [4];
  logic [FADE_W-1:0]         fv6, fw6;
  logic signed [BPROD_W-1:0] py7 [2];
  logic signed [LAYER_W-1:0] ay7 [2];
  logic [FADE_W-1:0]         fw7;
  logic signed [LAYER_W-1:0] ly8 [2];
  logic [FADE_W-1:0]         fw8;
  logic signed [BPROD_W-1:0] pz9;
  logic signed [LAYER_W-1:0] az9;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        px5[j] <= blend_mul(fade4[0], grad4[2*j], grad4[2*j+1]);
        ax5[j] <= grad4[2*j];
      end
      fv5 <= fade4[1];
      fw5 <= fade4[2];
      for (int j = 0; j < 4; j++) begin
        lx6[j] <= blend_add(ax5[j], px5[j]);
      end
      fv6 <= fv5;
      fw6 <= fw5;
      for (int j = 0; j < 2; j++) begin
        py7[j] <= blend_mul(fv6, lx6[2*j], lx6[2*j+1]);
        ay7[j] <= lx6[2*j];
      end
      fw7 <= fw6;
      for (int j = 0; j < 2; j++) begin
        ly8[j] <= blend_add(ay7[j], py7[j]);
      end
      fw8   <= fw7;
      pz9   <= blend_mul(fw8, ly8[0], ly8[1]);
      az9   <= ly8[0];
      layer <= blend_add(az9, pz9);
    end
  end

endmodule

FILE: src/fpn_accum.sv
// ----------------------------------------------------------------------------
// fpn_accum
// weighted octave sum: one octave per stage, weight chain carried along
// ----------------------------------------------------------------------------
module fpn_accum
  import fpn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8,
  parameter int TOT_W       = 41,
  parameter int MAXV_W      = 21
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [MAX_OCTAVES-1:0][LAYER_W-1:0] layers,
  input  oct_cfg_t                            cfg,
  output logic signed [TOT_W-1:0]             total,
  output logic [MAXV_W-1:0]                   maxv
);

  logic [AMP_W-1:0]                   amp  [MAX_OCTAVES];
  logic signed [PROD_W-1:0]           prod [MAX_OCTAVES];
  logic signed [TOT_W-1:0]            tot  [MAX_OCTAVES];
  logic [MAXV_W-1:0]                  mv   [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0][LAYER_W-1:0] lyr [MAX_OCTAVES];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    logic [AMP_W-1:0]                    amp_in;
    logic signed [PROD_W-1:0]            prod_in;
    logic signed [TOT_W-1:0]             tot_in;
    logic [MAXV_W-1:0]                   mv_in;
    logic [MAX_OCTAVES-1:0][LAYER_W-1:0] lyr_in;
    logic                                active;
    logic [AMP_W+PERS_W-1:0]             amp_prod;
    logic signed [PROD_W-1:0]            mul;

    if (k == 0) begin : g_src
      assign amp_in  = AMP_ONE;
      assign prod_in = '0;
      assign tot_in  = '0;
      assign mv_in   = '0;
      assign lyr_in  = layers;
    end else begin : g_src
      assign amp_in  = amp[k-1];
      assign prod_in = prod[k-1];
      assign tot_in  = tot[k-1];
      assign mv_in   = mv[k-1];
      assign lyr_in  = lyr[k-1];
    end

    assign active   = (OCT_CFG_W'(k) < cfg.count);
    assign amp_prod = (AMP_W+PERS_W)'(amp_in) * (AMP_W+PERS_W)'(cfg.persistence);
    assign mul      = PROD_W'($signed(lyr_in[k])) * PROD_W'($signed({1'b0, amp_in}));

    always_ff @(posedge clk) begin
      if (en) begin
        prod[k] <= active ? mul : '0;
        amp[k]  <= amp_prod[AMP_W+PERS_W-1:PERS_W];
        tot[k]  <= tot_in + TOT_W'(prod_in);
        mv[k]   <= mv_in + (active ? MAXV_W'(amp_in) : '0);
        lyr[k]  <= lyr_in;
      end
    end
  end

  // fold in the product of the last octave
  always_ff @(posedge clk) begin
    if (en) begin
      total <= tot[MAX_OCTAVES-1] + TOT_W'(prod[MAX_OCTAVES-1]);
      maxv  <= mv[MAX_OCTAVES-1];
    end
  end

endmodule

FILE: src/fpn_div.sv
// ----------------------------------------------------------------------------
// fpn_div
// pipelined restoring divider, one quotient bit per stage, saturation flag
// ----------------------------------------------------------------------------
module fpn_div
  import fpn_pkg::*;
#(
  parameter int TOT_W  = 41,
  parameter int MAXV_W = 21
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [TOT_W-1:0] total,
  input  logic [MAXV_W-1:0]       maxv,
  output div_res_t                res
);

  // magnitude of the dividend
  logic              neg_a;
  logic [TOT_W-1:0]  mag_a;
  logic [MAXV_W-1:0] d_a;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= total[TOT_W-1];
      mag_a <= total[TOT_W-1] ? (~total + TOT_W'(1)) : total;
      d_a   <= maxv;
    end
  end

  // quotient at or above the saturation limit
  logic              neg_o;
  logic              ovf_o;
  logic [TOT_W-1:0]  r_o;
  logic [MAXV_W-1:0] d_o;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_o <= neg_a;
      ovf_o <= (mag_a >> QUOT_W) >= TOT_W'(d_a);
      r_o   <= mag_a;
      d_o   <= d_a;
    end
  end

  logic              neg_s [QUOT_W];
  logic              ovf_s [QUOT_W];
  logic [TOT_W-1:0]  r_s   [QUOT_W];
  logic [QUOT_W-1:0] q_s   [QUOT_W];
  logic [MAXV_W-1:0] d_s   [QUOT_W];

  for (genvar j = 0; j < QUOT_W; j++) begin : g_bit
    localparam int B = QUOT_W - 1 - j;
    logic              neg_in;
    logic              ovf_in;
    logic [TOT_W-1:0]  r_in;
    logic [QUOT_W-1:0] q_in;
    logic [MAXV_W-1:0] d_in;
    logic              fits;
    logic [QUOT_W-1:0] q_next;

    if (j == 0) begin : g_src
      assign neg_in = neg_o;
      assign ovf_in = ovf_o;
      assign r_in   = r_o;
      assign q_in   = '0;
      assign d_in   = d_o;
    end else begin : g_src
      assign neg_in = neg_s[j-1];
      assign ovf_in = ovf_s[j-1];
      assign r_in   = r_s[j-1];
      assign q_in   = q_s[j-1];
      assign d_in   = d_s[j-1];
    end

    assign fits = (r_in >> B) >= TOT_W'(d_in);

    always_comb begin
      q_next    = q_in;
      q_next[B] = fits;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_s[j] <= neg_in;
        ovf_s[j] <= ovf_in;
        r_s[j]   <= fits ? (r_in - (TOT_W'(d_in) << B)) : r_in;
        q_s[j]   <= q_next;
        d_s[j]   <= d_in;
      end
    end
  end

  assign res = '{neg: neg_s[QUOT_W-1], ovf: ovf_s[QUOT_W-1], quot: q_s[QUOT_W-1]};

endmodule
